@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property holds at every clock edge, during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants shared by the pressure tendency tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

   localparam logic [16:0] P_MIN      = 17'd30000;
   localparam logic [16:0] P_MAX      = 17'd120000;
   localparam logic [17:0] GAIN_ONE   = 18'd65536;
   localparam logic [23:0] MS_PER_3H  = 24'd10800000;
   // span / 60000 = ((span >> 5) * MIN_RECIP) >> 38, exact for 32-bit spans
   localparam logic [27:0] MIN_RECIP  = 28'd146601551;

   localparam int unsigned ADDR_W = 5;

   // register byte addresses
   localparam logic [ADDR_W-1:0] REG_READ_INTERVAL  = 5'd0;
   localparam logic [ADDR_W-1:0] REG_TREND_INTERVAL = 5'd4;
   localparam logic [ADDR_W-1:0] REG_GAIN           = 5'd8;
   localparam logic [ADDR_W-1:0] REG_MIN_WINDOW     = 5'd12;
   localparam logic [ADDR_W-1:0] REG_TREND_THR      = 5'd16;
   localparam logic [ADDR_W-1:0] REG_FORECAST_THR   = 5'd20;
   localparam logic [ADDR_W-1:0] REG_HIGH_PRESSURE  = 5'd24;
   localparam logic [ADDR_W-1:0] REG_LOW_PRESSURE   = 5'd28;

   localparam logic [1:0] TREND_ACQUIRING = 2'd0;
   localparam logic [1:0] TREND_RISING    = 2'd1;
   localparam logic [1:0] TREND_FALLING   = 2'd2;
   localparam logic [1:0] TREND_STABLE    = 2'd3;

   localparam logic [2:0] FC_NO_DATA   = 3'd0;
   localparam logic [2:0] FC_IMPROVING = 3'd1;
   localparam logic [2:0] FC_WORSENING = 3'd2;
   localparam logic [2:0] FC_FAIR      = 3'd3;
   localparam logic [2:0] FC_RAIN      = 3'd4;
   localparam logic [2:0] FC_VARIABLE  = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SAMPLE,
      ST_READ,
      ST_SPAN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV,
      ST_LATCH,
      ST_WMIN,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

@@ rtl/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 20
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/pressure_tendency_tracker.sv @@
// ----------------------------------------------------------------------------
// pressure_tendency_tracker
// Barometric pressure tendency with sea-level scaling and forecast classes.
// ----------------------------------------------------------------------------
// One reading is handled at a time and each gives exactly one result beat.
// The input stalls from the accepting edge until the result beat is taken.
// A dropped reading goes straight to the result. One that does not enter
// the sample ring is scaled first. One that enters it is also written and
// looked up, and may then run through the bit-serial 56-step divider for
// the Pa per 3 h rate; the minutes come from a reciprocal multiply. The
// ring lives in two RAMs with a registered read; the oldest entry that a
// trend uses has always been written.
`default_nettype none

`include "assert_macros.svh"

module pressure_tendency_tracker
   import ptt_pkg::*;
#(
   parameter int HISTORY_DEPTH = 20,
   parameter int MIN_SAMPLES   = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [31:0]        req_timestamp_ms,
   input  wire logic [16:0]        req_pressure_pa,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic               rsp_accepted,
   output      logic               rsp_pressure_valid,
   output      logic [18:0]        rsp_sea_level_pa,
   output      logic               rsp_trend_valid,
   output      logic signed [15:0] rsp_trend_pa_per_3h,
   output      logic [15:0]        rsp_window_min,
   output      logic [1:0]         rsp_trend_class,
   output      logic [2:0]         rsp_forecast_class,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [ADDR_W-1:0]  paddr,
   input  wire logic [31:0]        pwdata,
   output      logic [31:0]        prdata,
   output      logic               pready
);

   localparam int IW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
   localparam logic [CW-1:0] MIN_C   = CW'(MIN_SAMPLES);

   // configuration
   logic [31:0] read_int_ff, trend_int_ff, min_win_ff;
   logic [17:0] gain_ff;
   logic [14:0] trend_thr_ff, fc_thr_ff;
   logic [18:0] high_p_ff, low_p_ff;

   logic cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_int_ff  <= 32'd60000;
         trend_int_ff <= 32'd600000;
         gain_ff      <= GAIN_ONE;
         min_win_ff   <= 32'd1800000;
         trend_thr_ff <= 15'd200;
         fc_thr_ff    <= 15'd250;
         high_p_ff    <= 19'd102200;
         low_p_ff     <= 19'd100000;
      end else if (cfg_wr) begin
         case (paddr)
            REG_READ_INTERVAL:  read_int_ff  <= pwdata;
            REG_TREND_INTERVAL: trend_int_ff <= pwdata;
            REG_GAIN:           gain_ff      <= pwdata[17:0];
            REG_MIN_WINDOW:     min_win_ff   <= pwdata;
            REG_TREND_THR:      trend_thr_ff <= pwdata[14:0];
            REG_FORECAST_THR:   fc_thr_ff    <= pwdata[14:0];
            REG_HIGH_PRESSURE:  high_p_ff    <= pwdata[18:0];
            REG_LOW_PRESSURE:   low_p_ff     <= pwdata[18:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         REG_READ_INTERVAL:  prdata = read_int_ff;
         REG_TREND_INTERVAL: prdata = trend_int_ff;
         REG_GAIN:           prdata = {14'd0, gain_ff};
         REG_MIN_WINDOW:     prdata = min_win_ff;
         REG_TREND_THR:      prdata = {17'd0, trend_thr_ff};
         REG_FORECAST_THR:   prdata = {17'd0, fc_thr_ff};
         REG_HIGH_PRESSURE:  prdata = {13'd0, high_p_ff};
         REG_LOW_PRESSURE:   prdata = {13'd0, low_p_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // state
   state_type   state_ff, state_in;
   logic [31:0] now_ff, now_in;
   logic [16:0] p_ff, p_in;
   logic        acc_ff, acc_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] last_read_ff, last_read_in;
   logic [31:0] last_trend_ff, last_trend_in;
   logic        has_sample_ff, has_sample_in;
   logic        pvalid_ff, pvalid_in;
   logic [18:0] sea_ff, sea_in;
   logic        tvalid_ff, tvalid_in;
   logic signed [15:0] rate_ff, rate_in;
   logic [15:0] window_ff, window_in;
   // datapath scratch
   logic [34:0] prod_ff, prod_in;
   logic [31:0] span_ff, span_in;
   logic        neg_ff, neg_in;
   logic [18:0] mag_ff, mag_in;
   logic [55:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  step_ff, step_in;
   logic [42:0] mlo_ff, mlo_in;

   // ring RAMs
   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   rd_time;
   logic [18:0]   rd_pres;

   ptt_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_time_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(now_ff),
      .rd_addr(ram_raddr), .rd_data(rd_time)
   );
   ptt_ram #(.WIDTH(19), .DEPTH(HISTORY_DEPTH)) u_pres_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(sea_ff),
      .rd_addr(ram_raddr), .rd_data(rd_pres)
   );

   logic [17:0] gain_eff;
   logic [31:0] oldest_sum;
   logic [32:0] rem_sh;
   logic [18:0] new_p;

   assign gain_eff = (gain_ff < GAIN_ONE) ? GAIN_ONE : gain_ff;

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      p_in          = p_ff;
      acc_in        = acc_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      last_read_in  = last_read_ff;
      last_trend_in = last_trend_ff;
      has_sample_in = has_sample_ff;
      pvalid_in     = pvalid_ff;
      sea_in        = sea_ff;
      tvalid_in     = tvalid_ff;
      rate_in       = rate_ff;
      window_in     = window_ff;
      prod_in       = prod_ff;
      span_in       = span_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      mlo_in        = mlo_ff;
      ram_we        = 1'b0;
      ram_waddr     = head_ff;
      oldest_sum    = 32'({1'b0, head_ff}) + 32'(HISTORY_DEPTH) - 32'(count_ff);
      if (oldest_sum >= 32'(HISTORY_DEPTH)) begin
         oldest_sum = oldest_sum - 32'(HISTORY_DEPTH);
      end
      ram_raddr = oldest_sum[IW-1:0];
      rem_sh    = {rem_ff[31:0], quot_ff[55]};
      new_p     = sea_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_timestamp_ms;
               p_in   = req_pressure_pa;
               acc_in = 1'b0;
               if ((req_timestamp_ms - last_read_ff) >= read_int_ff) begin
                  last_read_in = req_timestamp_ms;
                  if (req_pressure_pa >= P_MIN && req_pressure_pa <= P_MAX) begin
                     acc_in   = 1'b1;
                     state_in = ST_SCALE;
                  end else begin
                     state_in = ST_OUT;
                  end
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SCALE: begin
            prod_in  = 35'(p_ff) * 35'(gain_eff);
            state_in = ST_SAMPLE;
         end
         ST_SAMPLE: begin
            sea_in    = prod_ff[34:16];
            pvalid_in = 1'b1;
            if (has_sample_ff && (now_ff - last_trend_ff) < trend_int_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // write newest, advance head, then look up oldest
            has_sample_in = 1'b1;
            last_trend_in = now_ff;
            ram_we        = 1'b1;
            head_in       = (head_ff == IW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            if (count_ff < DEPTH_C) begin
               count_in = count_ff + 1'b1;
            end
            if (count_ff + 1'b1 < MIN_C && count_ff < DEPTH_C) begin
               tvalid_in = 1'b0;
               state_in  = ST_OUT;
            end else begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            // RAM read address now points at oldest entry (head/count updated)
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            span_in = now_ff - rd_time;
            if ((now_ff - rd_time) < min_win_ff) begin
               tvalid_in = 1'b0;
               state_in  = ST_OUT;
            end else begin
               neg_in = new_p < rd_pres;
               mag_in = (new_p < rd_pres) ? rd_pres - new_p : new_p - rd_pres;
               state_in = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            mlo_in  = 43'(mag_ff) * 43'(MS_PER_3H);
            quot_in = '0;
            rem_in  = '0;
            step_in = '0;
            state_in = ST_DIV;
            if (mag_ff == '0) begin
               rate_in  = '0;
               state_in = ST_LATCH;
            end else if (span_ff == '0) begin
               rate_in  = neg_ff ? -16'sd32768 : 16'sd32767;
               state_in = ST_LATCH;
            end
         end
         ST_DIV: begin
            // restoring divide, one bit a cycle; quot_ff shifts dividend out
            if (step_ff == 6'd0) begin
               quot_in = {13'd0, mlo_ff};
               step_in = 6'd1;
            end else begin
               if (rem_sh >= {1'b0, span_ff}) begin
                  rem_in  = rem_sh - {1'b0, span_ff};
                  quot_in = {quot_ff[54:0], 1'b1};
               end else begin
                  rem_in  = rem_sh;
                  quot_in = {quot_ff[54:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
               if (step_ff == 6'd56) begin
                  state_in = ST_LATCH;
                  if (neg_ff) begin
                     rate_in = (quot_in >= 56'd32768) ? -16'sd32768 : -$signed(quot_in[15:0]);
                  end else begin
                     rate_in = (quot_in >= 56'd32767) ? 16'sd32767 : $signed(quot_in[15:0]);
                  end
               end
            end
         end
         ST_LATCH: begin
            // minutes: (span / 32) / 1875 by reciprocal multiply
            quot_in  = 56'(span_ff[31:5]) * 56'(MIN_RECIP);
            state_in = ST_WMIN;
         end
         ST_WMIN: begin
            // quotient sits in bits 54:38, at most 17 bits wide
            window_in = quot_ff[54] ? 16'hFFFF : quot_ff[53:38];
            tvalid_in = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         last_read_ff  <= '0;
         last_trend_ff <= '0;
         has_sample_ff <= 1'b0;
         pvalid_ff     <= 1'b0;
         sea_ff        <= '0;
         tvalid_ff     <= 1'b0;
         rate_ff       <= '0;
         window_ff     <= '0;
         acc_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         last_read_ff  <= last_read_in;
         last_trend_ff <= last_trend_in;
         has_sample_ff <= has_sample_in;
         pvalid_ff     <= pvalid_in;
         sea_ff        <= sea_in;
         tvalid_ff     <= tvalid_in;
         rate_ff       <= rate_in;
         window_ff     <= window_in;
         acc_ff        <= acc_in;
      end
      now_ff  <= now_in;
      p_ff    <= p_in;
      prod_ff <= prod_in;
      span_ff <= span_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      mlo_ff  <= mlo_in;
   end

   // result beat
   logic signed [15:0] thr_s, fthr_s;
   assign thr_s  = $signed({1'b0, trend_thr_ff});
   assign fthr_s = $signed({1'b0, fc_thr_ff});

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = (state_ff == ST_OUT);
   assign rsp_accepted        = acc_ff;
   assign rsp_pressure_valid  = pvalid_ff;
   assign rsp_sea_level_pa    = sea_ff;
   assign rsp_trend_valid     = tvalid_ff;
   assign rsp_trend_pa_per_3h = rate_ff;
   assign rsp_window_min      = window_ff;

   always_comb begin
      if (!tvalid_ff)              rsp_trend_class = TREND_ACQUIRING;
      else if (rate_ff >= thr_s)   rsp_trend_class = TREND_RISING;
      else if (rate_ff <= -thr_s)  rsp_trend_class = TREND_FALLING;
      else                         rsp_trend_class = TREND_STABLE;

      if (!pvalid_ff)                          rsp_forecast_class = FC_NO_DATA;
      else if (tvalid_ff && rate_ff >= fthr_s)  rsp_forecast_class = FC_IMPROVING;
      else if (tvalid_ff && rate_ff <= -fthr_s) rsp_forecast_class = FC_WORSENING;
      else if (sea_ff >= high_p_ff)            rsp_forecast_class = FC_FAIR;
      else if (sea_ff <= low_p_ff)             rsp_forecast_class = FC_RAIN;
      else                                     rsp_forecast_class = FC_VARIABLE;
   end

   `ASSERT_CLK(a_one_side, clock, reset, !(rsp_valid && !req_stall), "result and input open together")
   `ASSERT_CLK(a_count_max, clock, reset, count_ff <= DEPTH_C, "ring count past depth")
   `ASSERT_CLK(a_tvalid_count, clock, reset, !tvalid_ff || count_ff >= MIN_C, "trend valid with few samples")
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE), "not idle after reset")

endmodule

`default_nettype wire
